### rtl/core/bldf_pkg.sv
// Shared types and constants for the backlight auto-dim fader.
// Used by bldf_ctrl, bldf_dp and backlight_auto_dim_fader_unit; no dependencies.
`default_nettype none

package bldf_pkg;

    localparam int PCT_W     = 7;
    localparam int TIME_W    = 32;
    localparam int FADE_W    = 16;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    // dividend width: 100 * 65535 fits, and so does level * duty scale
    localparam int NUM_W     = 23;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [PCT_W-1:0]  PCT_MAX = 7'd100;

    // duty scaling: x / 100 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^23
    localparam int RECIP_W   = 24;
    localparam int PCT_SHIFT = 30;
    localparam int RPROD_W   = PCT_SHIFT + DUTY_W;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;

    // opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic fade_chk;
        logic mul_a;
        logic div_load_fade;
        logic div_load_duty;
        logic div_step;
        logic level_wb;
        logic duty_wb;
        logic out_load;
    } bldf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic wrote;
        logic div_done;
        logic out_free;
    } bldf_sts_t;

    // clamp a percent value to 100
    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bldf_ctrl.sv
// Sequencing state machine for the backlight auto-dim fader.
// Depends on bldf_pkg for the command and status structs.
`default_nettype none

module bldf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  bldf_pkg::bldf_sts_t      sts,
    output bldf_pkg::bldf_cmd_t      cmd
);
    import bldf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_FADE = 4'd2;
    localparam logic [3:0] S_MULA = 4'd3;
    localparam logic [3:0] S_MULB = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_LWB  = 4'd6;
    localparam logic [3:0] S_DMUL = 4'd7;
    localparam logic [3:0] S_DWB  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FADE;
            end
            S_FADE:
            begin
                cmd.fade_chk = 1'b1;
                if (sts.need_div)
                    state_next = S_MULA;
                else if (sts.wrote)
                    state_next = S_DMUL;
                else
                    state_next = S_OUT;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.div_load_fade = 1'b1;
                state_next        = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_LWB;
            end
            S_LWB:
            begin
                cmd.level_wb = 1'b1;
                state_next   = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.div_load_duty = 1'b1;
                state_next        = S_DWB;
            end
            S_DWB:
            begin
                cmd.duty_wb = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/core/bldf_dp.sv
// Datapath of the backlight auto-dim fader: config, fader state, shared
// multiplier, serial divider and output register. Depends on bldf_pkg.
`default_nettype none

module bldf_dp #(
    parameter int DUTY_MAX = 255
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [bldf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bldf_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire logic                             opcode,
    input  wire logic [bldf_pkg::TIME_W-1:0]      now_ms,
    input  wire logic                             activity,
    input  wire logic [bldf_pkg::PCT_W-1:0]       level,
    input  bldf_pkg::bldf_cmd_t                   cmd,
    output bldf_pkg::bldf_sts_t                   sts,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [bldf_pkg::DUTY_W-1:0]           duty,
    output logic                                  duty_update,
    output logic [bldf_pkg::PCT_W-1:0]            level_pct,
    output logic                                  fading
);
    import bldf_pkg::*;

    localparam logic [FADE_W-1:0] DUTY_K   = FADE_W'(DUTY_MAX);
    // full level 100 maps to DUTY_MAX exactly
    localparam logic [DUTY_W-1:0] DUTY_RST = DUTY_W'(DUTY_MAX);

    // configuration
    logic [PCT_W-1:0]  full_lvl_reg;
    logic [PCT_W-1:0]  dim_lvl_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [FADE_W-1:0] fade_len_reg;

    // captured item
    logic              op_reg;
    logic [TIME_W-1:0] now_reg;
    logic              act_reg;
    logic [PCT_W-1:0]  lvl_reg;

    // fader state
    logic [PCT_W-1:0]  cur_reg,  cur_next;
    logic [PCT_W-1:0]  tgt_reg,  tgt_next;
    logic [PCT_W-1:0]  fsl_reg,  fsl_next;
    logic [TIME_W-1:0] fst_reg,  fst_next;
    logic              fade_reg, fade_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic              wrote_reg, wrote_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    // arithmetic
    logic [FADE_W-1:0] elapsed_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [FADE_W-1:0] rem_reg;
    logic [FADE_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // output register
    logic              out_valid_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_upd_reg;
    logic [PCT_W-1:0]  out_lvl_reg;
    logic              out_fade_reg;

    logic [PCT_W-1:0]  full_sat;
    logic [TIME_W-1:0] idle_time;
    logic              timed_out;
    logic [TIME_W-1:0] since;
    logic              fade_over;
    logic              quiet_tick;
    logic [PCT_W-1:0]  mul_a_op;
    logic [FADE_W-1:0] mul_b_op;
    logic [NUM_W-1:0]  prod;
    logic [FADE_W:0]   div_sh;
    logic [FADE_W:0]   div_diff;
    logic              div_ge;
    logic [RPROD_W-1:0] duty_prod;

    assign full_sat   = sat_pct(full_lvl_reg);
    assign idle_time  = now_reg - last_reg;
    assign timed_out  = (idle_time >= timeout_reg);
    assign since      = now_reg - fst_reg;
    assign fade_over  = (since >= TIME_W'(fade_len_reg));
    assign quiet_tick = (op_reg == OP_TICK) && !act_reg;

    // shared 7x16 multiplier
    always_comb
    begin
        if (cmd.mul_a)
        begin
            mul_a_op = fsl_reg;
            mul_b_op = fade_len_reg - elapsed_reg;
        end
        else if (cmd.div_load_fade)
        begin
            mul_a_op = tgt_reg;
            mul_b_op = elapsed_reg;
        end
        else
        begin
            mul_a_op = cur_reg;
            mul_b_op = DUTY_K;
        end
    end
    assign prod = NUM_W'(mul_a_op) * NUM_W'(mul_b_op);

    // one restoring division step
    assign div_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge   = (div_sh >= {1'b0, den_reg});
    assign div_diff = div_sh - {1'b0, den_reg};

    // duty scaling by 100 through the reciprocal
    assign duty_prod = RPROD_W'(num_reg) * RPROD_W'(PCT_RECIP);

    // fader state update
    always_comb
    begin
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        fsl_next   = fsl_reg;
        fst_next   = fst_reg;
        fade_next  = fade_reg;
        last_next  = last_reg;
        wrote_next = wrote_reg;
        duty_next  = duty_reg;
        if (cmd.capture)
            wrote_next = 1'b0;
        if (cmd.eval)
        begin
            if (op_reg == OP_SET)
            begin
                cur_next   = sat_pct(lvl_reg);
                tgt_next   = sat_pct(lvl_reg);
                fade_next  = 1'b0;
                wrote_next = 1'b1;
            end
            else if (act_reg)
            begin
                last_next = now_reg;
                if (fade_reg || (cur_reg != full_sat))
                begin
                    cur_next   = full_sat;
                    tgt_next   = full_sat;
                    fade_next  = 1'b0;
                    wrote_next = 1'b1;
                end
            end
            else if (!fade_reg && (tgt_reg == full_sat) && timed_out)
            begin
                // inactivity timeout: begin the fade now
                fsl_next  = cur_reg;
                tgt_next  = sat_pct(dim_lvl_reg);
                fst_next  = now_reg;
                fade_next = 1'b1;
            end
        end
        if (cmd.fade_chk && quiet_tick && fade_reg)
        begin
            wrote_next = 1'b1;
            if (fade_over)
            begin
                cur_next  = tgt_reg;
                fade_next = 1'b0;
            end
        end
        if (cmd.level_wb)
            cur_next = num_reg[PCT_W-1:0];
        if (cmd.duty_wb)
            duty_next = duty_prod[PCT_SHIFT +: DUTY_W];
    end

    // status to controller
    always_comb
    begin
        sts.need_div = quiet_tick && fade_reg && !fade_over;
        sts.wrote    = wrote_next;
        sts.div_done = (cnt_reg == '0);
        sts.out_free = !out_valid_reg || out_ready;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_lvl_reg  <= PCT_MAX;
            dim_lvl_reg   <= 7'd20;
            timeout_reg   <= 32'd30000;
            fade_len_reg  <= 16'd1000;
            cur_reg       <= PCT_MAX;
            tgt_reg       <= PCT_MAX;
            fsl_reg       <= '0;
            fst_reg       <= '0;
            fade_reg      <= 1'b0;
            last_reg      <= '0;
            wrote_reg     <= 1'b0;
            duty_reg      <= DUTY_RST;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FULL:    full_lvl_reg <= cfg_data[PCT_W-1:0];
                    REG_DIM:     dim_lvl_reg  <= cfg_data[PCT_W-1:0];
                    REG_TIMEOUT: timeout_reg  <= cfg_data[TIME_W-1:0];
                    REG_FADE:    fade_len_reg <= cfg_data[FADE_W-1:0];
                    default:     ;
                endcase
            end
            cur_reg   <= cur_next;
            tgt_reg   <= tgt_next;
            fsl_reg   <= fsl_next;
            fst_reg   <= fst_next;
            fade_reg  <= fade_next;
            last_reg  <= last_next;
            wrote_reg <= wrote_next;
            duty_reg  <= duty_next;
            if (cmd.div_load_fade)
                cnt_reg <= CNT_W'(NUM_W - 1);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            now_reg <= now_ms;
            act_reg <= activity;
            lvl_reg <= level;
        end
        if (cmd.fade_chk)
            elapsed_reg <= since[FADE_W-1:0];
        if (cmd.mul_a)
            acc_reg <= prod;
        if (cmd.div_load_fade)
        begin
            num_reg <= acc_reg + prod;
            den_reg <= fade_len_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_load_duty)
        begin
            num_reg <= prod;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[FADE_W-1:0] : div_sh[FADE_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_duty_reg <= duty_reg;
            out_upd_reg  <= wrote_reg;
            out_lvl_reg  <= cur_reg;
            out_fade_reg <= fade_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty        = out_duty_reg;
    assign duty_update = out_upd_reg;
    assign level_pct   = out_lvl_reg;
    assign fading      = out_fade_reg;

endmodule

`default_nettype wire

### rtl/core/backlight_auto_dim_fader_unit.sv
// Top level of the backlight auto-dim fader.
// Instantiates bldf_ctrl and bldf_dp; depends on bldf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a tick (opcode 0)
//   with now_ms and activity, or a set-level command (opcode 1) with level.
//   Every item yields exactly one result on the output channel
//   (out_valid/out_ready): duty, duty_update, level_pct and fading.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//   cfg_ready is always high. Write registers only while the block is idle.
// Steps from accept to result: capture, evaluate and fade check, then
//   the output load. A new duty adds the duty multiply and write-back, and
//   a fade step first runs the serial divider, which takes one quotient
//   bit per cycle over 23 bits. The duty is scaled by a reciprocal multiply.
// One item is worked on at a time; the next is taken the cycle after its
// result is loaded into the output register.
// Reset: full brightness (level 100, duty = DUTY_MAX), no fade, register
// defaults loaded. A stalled receiver holds the result in the output
// register and the next item waits in its final state until it drains.
`default_nettype none

module backlight_auto_dim_fader_unit #(
    parameter int DUTY_MAX = 255
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bldf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bldf_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             opcode,
    input  wire logic [bldf_pkg::TIME_W-1:0]      now_ms,
    input  wire logic                             activity,
    input  wire logic [bldf_pkg::PCT_W-1:0]       level,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bldf_pkg::DUTY_W-1:0]           duty,
    output logic                                  duty_update,
    output logic [bldf_pkg::PCT_W-1:0]            level_pct,
    output logic                                  fading
);
    import bldf_pkg::*;

    bldf_cmd_t cmd;
    bldf_sts_t sts;

    assign cfg_ready = 1'b1;

    bldf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bldf_dp #(
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .now_ms      (now_ms),
        .activity    (activity),
        .level       (level),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .duty        (duty),
        .duty_update (duty_update),
        .level_pct   (level_pct),
        .fading      (fading)
    );

    // a result still fading must have written a duty
    a_fade_writes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fading |-> duty_update)
        else $error("fading result without duty update");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // reported level never exceeds 100 percent
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_pct <= PCT_MAX)
        else $error("level above 100 percent");

endmodule

`default_nettype wire
